@@ sv/swbc_pkg.sv @@
// ----------------------------------------------------------------------------
// swbc_pkg
// Shared types and constants of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package swbc_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_READ_DATA = 2'd0,
    KIND_FETCH     = 2'd1,
    KIND_WRITE_OK  = 2'd2,
    KIND_WRITEBACK = 2'd3
  } kind_e;

  localparam int unsigned SEED_W    = 11;
  localparam int unsigned SEED_STEP = 7;
  localparam int unsigned SEED_WRAP = 1543;
  localparam int unsigned VICT_ADD  = 422;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input item, start set read
    logic decide;    // registered set data valid: resolve and update
    logic emit_wb;   // present write-back result
    logic emit_main; // present final result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic need_wb;   // item causes a write-back
    logic no_result; // unknown action
    logic clearing;  // valid and dirty bits still being cleared after reset
  } stat_t;

endpackage

@@ sv/swbc_datapath.sv @@
// ----------------------------------------------------------------------------
// swbc_datapath
// Set memories, tag compare, victim choice, counters and result register.
// ----------------------------------------------------------------------------
module swbc_datapath #(
  parameter int unsigned SETS = 128,
  parameter int unsigned WAYS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swbc_pkg::ctrl_t      ctrl_i,
  output swbc_pkg::stat_t      stat_o,
  input  logic [1:0]           action_i,
  input  logic [31:0]          address_i,
  input  logic [31:0]          data_i,
  output logic [1:0]           kind_o,
  output logic [31:0]          result_address_o,
  output logic [31:0]          result_data_o,
  output logic                 last_o,
  output logic [31:0]          access_count_o,
  output logic [31:0]          miss_count_o
);

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  // floor(s/3) == (s*683) >> 11 for every s below 2048
  localparam int unsigned DIV3_MUL = 683;

  // tag and word memories, one row of WAYS entries per set
  logic [WAYS-1:0][31:0] tag_mem  [SETS];
  logic [WAYS-1:0][31:0] word_mem [SETS];
  // valid and dirty bits, cleared by a pass over the sets after reset
  logic [WAYS-1:0] valid_q [SETS];
  logic [WAYS-1:0] dirty_q [SETS];

  logic [WAYS-1:0][31:0] tag_rd_q, word_rd_q;
  logic [WAYS-1:0]       valid_rd_q, dirty_rd_q;

  logic [1:0]        act_q;
  logic [31:0]       addr_q, data_q;
  logic [SET_W-1:0]  set_q;
  logic [SET_W-1:0]  set_in;

  logic [swbc_pkg::SEED_W-1:0] seed_q, seed_d;
  logic [31:0] reads_q, misses_q;

  logic [SET_W:0]   clr_cnt_q;
  logic [SET_W-1:0] clr_idx;
  logic             clearing;

  // per-item resolution, registered at decide
  logic [1:0]  main_kind_q;
  logic [31:0] main_data_q;
  logic [31:0] wb_addr_q, wb_data_q;

  assign set_in = (SETS > 1) ? SET_W'(address_i % SETS) : '0;

  assign clearing = (clr_cnt_q < (SET_W+1)'(SETS));
  assign clr_idx  = clr_cnt_q[SET_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      act_q      <= action_i;
      addr_q     <= address_i;
      data_q     <= data_i;
      set_q      <= set_in;
      tag_rd_q   <= tag_mem[set_in];
      word_rd_q  <= word_mem[set_in];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_rd_q <= '0;
      dirty_rd_q <= '0;
    end else if (ctrl_i.capture) begin
      valid_rd_q <= valid_q[set_in];
      dirty_rd_q <= dirty_q[set_in];
    end
  end

  // hit and free-way search
  logic [WAYS-1:0]  hit_vec;
  logic             hit, has_free;
  logic [WAY_W-1:0] hit_way, free_way, vict_way, slot;

  always_comb begin
    hit = 1'b0; hit_way = '0; has_free = 1'b0; free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = valid_rd_q[w] && (tag_rd_q[w] == addr_q);
      if (hit_vec[w]) begin
        hit = 1'b1; hit_way = WAY_W'(w);
      end
      if (!valid_rd_q[w]) begin
        has_free = 1'b1; free_way = WAY_W'(w);
      end
    end
  end

  // victim from seed: (s*s + 422 + s/3) mod WAYS
  logic [21:0] sq;
  logic [20:0] div3_prod;
  logic [22:0] vsum;
  assign sq        = 22'(seed_q) * 22'(seed_q);
  assign div3_prod = 21'(seed_q) * 21'(DIV3_MUL);
  assign vsum      = 23'(sq) + 23'(swbc_pkg::VICT_ADD) + 23'(div3_prod[20:11]);
  assign vict_way  = (WAYS > 1) ? WAY_W'(vsum % WAYS) : '0;

  always_comb begin
    priority if (hit)   slot = hit_way;
    else if (has_free)  slot = free_way;
    else                slot = vict_way;
  end

  logic is_rd, is_wr, is_fl, alloc, wb;
  assign is_rd  = (act_q == swbc_pkg::ACT_READ);
  assign is_wr  = (act_q == swbc_pkg::ACT_WRITE);
  assign is_fl  = (act_q == swbc_pkg::ACT_FILL);
  assign alloc  = (is_wr || is_fl) && !hit;
  assign wb     = alloc && !has_free && dirty_rd_q[vict_way];

  assign stat_o.need_wb   = wb;
  assign stat_o.no_result = (act_q == swbc_pkg::ACT_NONE);
  assign stat_o.clearing  = clearing;

  always_comb begin
    seed_d = seed_q + swbc_pkg::SEED_W'(swbc_pkg::SEED_STEP);
    if (seed_d > swbc_pkg::SEED_W'(swbc_pkg::SEED_WRAP))
      seed_d = seed_d - swbc_pkg::SEED_W'(swbc_pkg::SEED_WRAP);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.decide) begin
      wb_addr_q <= tag_rd_q[vict_way];
      wb_data_q <= word_rd_q[vict_way];
      if (is_wr || (is_fl && !hit)) begin
        tag_mem[set_q][slot]  <= addr_q;
        word_mem[set_q][slot] <= data_q;
      end
      unique case (act_q)
        swbc_pkg::ACT_READ:  begin
          main_kind_q <= hit ? swbc_pkg::KIND_READ_DATA : swbc_pkg::KIND_FETCH;
          main_data_q <= hit ? word_rd_q[hit_way] : '0;
        end
        swbc_pkg::ACT_WRITE: begin
          main_kind_q <= swbc_pkg::KIND_WRITE_OK;
          main_data_q <= '0;
        end
        swbc_pkg::ACT_FILL:  begin
          main_kind_q <= swbc_pkg::KIND_READ_DATA;
          main_data_q <= hit ? word_rd_q[hit_way] : data_q;
        end
        default: begin
          main_kind_q <= swbc_pkg::KIND_READ_DATA;
          main_data_q <= '0;
        end
      endcase
    end
  end

  // valid and dirty memories: clear one set per cycle after reset
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      valid_q[clr_idx] <= '0;
      dirty_q[clr_idx] <= '0;
    end else if (ctrl_i.decide) begin
      if (is_wr) begin
        valid_q[set_q][slot] <= 1'b1;
        dirty_q[set_q][slot] <= 1'b1;
      end else if (is_fl && !hit) begin
        valid_q[set_q][slot] <= 1'b1;
        dirty_q[set_q][slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      reads_q   <= '0;
      misses_q  <= '0;
    end else if (ctrl_i.decide) begin
      if (is_rd) begin
        reads_q <= reads_q + 32'd1;
        if (!hit) misses_q <= misses_q + 32'd1;
      end
      if (is_wr || is_fl) seed_q <= seed_d;
    end
  end

  // output mux: write-back first, then main result
  assign kind_o           = ctrl_i.emit_wb ? swbc_pkg::KIND_WRITEBACK : main_kind_q;
  assign result_address_o = ctrl_i.emit_wb ? wb_addr_q : addr_q;
  assign result_data_o    = ctrl_i.emit_wb ? wb_data_q : main_data_q;
  assign last_o           = ctrl_i.emit_main;
  assign access_count_o   = reads_q;
  assign miss_count_o     = misses_q;

endmodule

@@ sv/swbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// swbc_ctrl
// Sequencer: accept, look up and resolve, then present up to two results.
// ----------------------------------------------------------------------------
module swbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  swbc_pkg::stat_t stat_i,
  output swbc_pkg::ctrl_t ctrl_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOOK = 5'b00010,
    ST_WB   = 5'b00100,
    ST_MAIN = 5'b01000,
    ST_GAP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_take;

  assign out_take = !out_stall_i;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && !stat_i.clearing) begin
        ctrl_o.capture = 1'b1;
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        ctrl_o.decide = 1'b1;
        priority if (stat_i.no_result) state_d = ST_IDLE;
        else if (stat_i.need_wb)       state_d = ST_WB;
        else                           state_d = ST_MAIN;
      end
      ST_WB: begin
        ctrl_o.emit_wb = 1'b1;
        if (out_take) state_d = ST_MAIN;
      end
      ST_MAIN: begin
        ctrl_o.emit_main = 1'b1;
        if (out_take) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE) || stat_i.clearing;
  assign out_valid_o = (state_q == ST_WB) || (state_q == ST_MAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

@@ sv/set_assoc_writeback_cache.sv @@
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache
// Word-granular set-associative write-back cache with pseudo-random victims.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with action, address and data.
// Output channel: out_valid_o / out_stall_i with kind, address, data, last
// and the running read and read-miss counters.
// One item at a time: the set's row is read in the accept cycle, the next
// cycle compares tags and updates the set, then results are presented.
// An item without write-back goes through accept, lookup and result; one with
// a write-back adds a write-back result first; the single set read port and
// the sequencer set this. The unknown action gives no result and frees the
// input after the lookup. A stalled result holds; the input stays stalled
// until the last result of the item is taken. Reset clears the seed and both
// counters at once and starts a clearing pass over the valid and dirty bits
// of all SETS sets (128 by default), one set per cycle, stalling the input.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache #(
  parameter int unsigned SETS = 128,
  parameter int unsigned WAYS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [31:0] data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] result_address_o,
  output logic [31:0] result_data_o,
  output logic        last_o,
  output logic [31:0] access_count_o,
  output logic [31:0] miss_count_o
);

  swbc_pkg::ctrl_t ctrl;
  swbc_pkg::stat_t stat;

  swbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  swbc_datapath #(.SETS(SETS), .WAYS(WAYS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .action_i, .address_i, .data_i,
    .kind_o, .result_address_o, .result_data_o, .last_o,
    .access_count_o, .miss_count_o
  );

  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("result after last");
  a_wb_then_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("write-back not followed by final result");
  a_wb_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> kind_o == swbc_pkg::KIND_WRITEBACK)
    else $error("non-final result is not a write-back");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Random and directed test of the set-associative write-back cache: a
// behavioral cache model predicts every result and a checker compares them.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NSETS = 128;
  localparam int unsigned NWAYS = 8;

  typedef struct {
    swbc_pkg::kind_e kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
    logic [31:0] reads;
    logic [31:0] misses;
  } cache_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [31:0] address;
  logic [31:0] data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [31:0] res_addr;
  logic [31:0] res_data;
  logic        last;
  logic [31:0] acc_cnt;
  logic [31:0] miss_cnt;

  set_assoc_writeback_cache #(.SETS(NSETS), .WAYS(NWAYS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .address_i(address), .data_i(data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .result_address_o(res_addr), .result_data_o(res_data),
    .last_o(last), .access_count_o(acc_cnt), .miss_count_o(miss_cnt)
  );

  // model state
  bit          line_valid [NSETS*NWAYS];
  bit          line_dirty [NSETS*NWAYS];
  logic [31:0] line_tag   [NSETS*NWAYS];
  logic [31:0] line_word  [NSETS*NWAYS];
  logic [10:0] seed;
  logic [31:0] reads_seen;
  logic [31:0] reads_missed;

  cache_result_t expected_q[$];
  int          errors;
  int          results_seen;
  int          writebacks_seen;
  bit          idle_en;
  int          hold_cycles;
  logic [31:0] pending_fetch[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void push_result(swbc_pkg::kind_e k, logic [31:0] a, logic [31:0] d);
    cache_result_t r;
    r.kind = k;
    r.addr = a;
    r.data = d;
    r.last = 1'b0;
    r.reads = reads_seen;
    r.misses = reads_missed;
    expected_q.push_back(r);
  endfunction

  function automatic int lookup_way(int base, logic [31:0] a);
    for (int w = 0; w < NWAYS; w++)
      if (line_valid[base+w] && line_tag[base+w] == a) return w;
    return -1;
  endfunction

  function automatic int choose_slot(int base);
    int unsigned s;
    int slot;
    for (int w = 0; w < NWAYS; w++)
      if (!line_valid[base+w]) return base + w;
    s = seed;
    slot = base + int'((s * s + swbc_pkg::VICT_ADD + s / 3) % NWAYS);
    if (line_dirty[slot])
      push_result(swbc_pkg::KIND_WRITEBACK, line_tag[slot], line_word[slot]);
    return slot;
  endfunction

  function automatic void advance_seed();
    int unsigned s;
    s = seed + swbc_pkg::SEED_STEP;
    if (s > swbc_pkg::SEED_WRAP) s -= swbc_pkg::SEED_WRAP;
    seed = s[10:0];
  endfunction

  function automatic void predict_cache(swbc_pkg::action_e act, logic [31:0] a,
                                        logic [31:0] d);
    int base;
    int w;
    int slot;
    int first;
    base = int'(a % NSETS) * NWAYS;
    first = expected_q.size();
    case (act)
      swbc_pkg::ACT_READ: begin
        reads_seen++;
        w = lookup_way(base, a);
        if (w >= 0) begin
          push_result(swbc_pkg::KIND_READ_DATA, a, line_word[base+w]);
        end else begin
          reads_missed++;
          push_result(swbc_pkg::KIND_FETCH, a, 32'd0);
        end
      end
      swbc_pkg::ACT_WRITE: begin
        w = lookup_way(base, a);
        slot = (w >= 0) ? base + w : choose_slot(base);
        line_valid[slot] = 1'b1;
        line_dirty[slot] = 1'b1;
        line_tag[slot] = a;
        line_word[slot] = d;
        advance_seed();
        push_result(swbc_pkg::KIND_WRITE_OK, a, 32'd0);
      end
      swbc_pkg::ACT_FILL: begin
        w = lookup_way(base, a);
        if (w >= 0) begin
          slot = base + w;
        end else begin
          slot = choose_slot(base);
          line_valid[slot] = 1'b1;
          line_dirty[slot] = 1'b0;
          line_tag[slot] = a;
          line_word[slot] = d;
        end
        advance_seed();
        push_result(swbc_pkg::KIND_READ_DATA, a, line_word[slot]);
      end
      default: ;
    endcase
    // counters are reported as they stand after the item
    for (int i = first; i < expected_q.size(); i++) begin
      expected_q[i].reads = reads_seen;
      expected_q[i].misses = reads_missed;
    end
    if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(swbc_pkg::action_e act, logic [31:0] a, logic [31:0] d);
    while (idle_en && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    address <= a;
    data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cache(act, a, d);
    if (act == swbc_pkg::ACT_READ &&
        expected_q[expected_q.size()-1].kind == swbc_pkg::KIND_FETCH)
      pending_fetch.push_back(a);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < 21);
    end
  end

  // result checker
  always @(posedge clk) begin
    cache_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (kind == swbc_pkg::KIND_WRITEBACK) writebacks_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d addr=%h", kind, res_addr);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, kind); errors++;
        end
        if (res_addr !== e.addr) begin
          $error("result_address: expected %h actual %h", e.addr, res_addr); errors++;
        end
        if (res_data !== e.data) begin
          $error("result_data: expected %h actual %h", e.data, res_data); errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, last); errors++;
        end
        if (acc_cnt !== e.reads) begin
          $error("access_count: expected %0d actual %0d", e.reads, acc_cnt); errors++;
        end
        if (miss_cnt !== e.misses) begin
          $error("miss_count: expected %0d actual %0d", e.misses, miss_cnt); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    idle_en = 1'b0;
    send_item(swbc_pkg::ACT_READ, 32'h0000_0000, 32'h0);           // miss in empty cache
    send_item(swbc_pkg::ACT_FILL, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(swbc_pkg::ACT_READ, 32'h0000_0000, 32'h0);           // hit
    send_item(swbc_pkg::ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(swbc_pkg::ACT_READ, 32'hFFFF_FFFF, 32'h0);
    send_item(swbc_pkg::ACT_FILL, 32'hFFFF_FFFF, 32'h1234_5678);   // fill of cached line
    send_item(swbc_pkg::ACT_NONE, 32'h5555_5555, 32'hAAAA_AAAA);   // ignored
    // overfill set 5 with dirty lines to force write-backs
    for (int i = 0; i < 12; i++)
      send_item(swbc_pkg::ACT_WRITE, 32'd5 + NSETS * i, 32'hA5A5_0000 + i);
    send_item(swbc_pkg::ACT_FILL, 32'd5 + NSETS * 40, 32'h0BAD_F00D);
    send_item(swbc_pkg::ACT_READ, 32'd5 + NSETS * 40, 32'h0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [31:0] a;
    int r;
    idle_en = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) idle_en = 1'b0;        // stretch with no idling
      if (i == n / 2 + 150) idle_en = 1'b1;
      r = $urandom_range(99);
      // small tag pool per set to get hits and evictions; some full-range
      a = ($urandom_range(9) == 0) ? $urandom()
          : ($urandom_range(15) * NSETS + $urandom_range(3) * 37);
      if (r < 35) begin
        send_item(swbc_pkg::ACT_READ, a, $urandom());
      end else if (r < 70) begin
        send_item(swbc_pkg::ACT_WRITE, a, $urandom());
      end else if (r < 97) begin
        if (pending_fetch.size() != 0 && $urandom_range(3) != 0)
          a = pending_fetch.pop_front();
        send_item(swbc_pkg::ACT_FILL, a, $urandom());
      end else begin
        send_item(swbc_pkg::ACT_NONE, a, $urandom());
      end
    end
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 20; i++)
      send_item(swbc_pkg::action_e'($urandom_range(2)), $urandom_range(63), $urandom());
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    action = swbc_pkg::ACT_READ;
    address = '0;
    data = '0;
    out_stall = 1'b0;
    hold_cycles = 0;
    idle_en = 1'b0;
    errors = 0;
    results_seen = 0;
    writebacks_seen = 0;
    seed = '0;
    reads_seen = '0;
    reads_missed = '0;
    foreach (line_valid[i]) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_tag[i] = '0;
      line_word[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(1100);
    wait_drained();
    $display("covered reads, writes, fills, ignored actions: %0d results, %0d write-backs",
             results_seen, writebacks_seen);
    if (errors == 0) $display("set_assoc_writeback_cache test passed");
    else $display("set_assoc_writeback_cache test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("set_assoc_writeback_cache test failed");
    $finish;
  end
endmodule

@@ files.f @@
sv/swbc_pkg.sv
sv/swbc_datapath.sv
sv/swbc_ctrl.sv
sv/set_assoc_writeback_cache.sv
tb/tb.sv
